/* src/bev_pkg.sv */
// ---------------------------------------------------------------------------
// bev_pkg: shared types and constants
// Status codes, mode codes, limits and the command and status bundles that
// join the controller and the datapath of the eviction block.
// ---------------------------------------------------------------------------
package bev_pkg;

  localparam int unsigned X_W      = 32;
  localparam int unsigned FRAME_W  = 32;
  localparam int unsigned SIZE_W   = 24;
  localparam int unsigned BUDGET_W = 31;
  localparam int unsigned PROT_W   = 8;
  localparam int unsigned UOUT_W   = 30;
  localparam int unsigned N_W      = 7;

  localparam logic [N_W-1:0]      RESULT_CAP    = 7'd64;
  localparam logic [BUDGET_W-1:0] BUDGET_FLOOR  = 31'd1048576;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET  = 31'd268435456;
  localparam logic [PROT_W-1:0]   PROTECT_RESET = 8'd60;
  localparam logic [UOUT_W-1:0]   USAGE_MAX     = 30'h3fff_ffff;

  typedef enum logic [1:0] {
    MODE_TOUCH   = 2'd0,
    MODE_FILL    = 2'd1,
    MODE_ENFORCE = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EVICTED = 2'd1,
    ST_NONE    = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_BUDGET  = 1'b0,
    REG_PROTECT = 1'b1
  } reg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch;
    logic    scan_start;
    logic    scan_age;
    logic    apply_key;
    logic    init_enf;
    logic    decide;
    logic    emit_direct;
    logic    emit_pend;
    status_t emit_status;
    logic    emit_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_t mode;
    logic  scan_done;
    logic  hit;
    logic  best_ok;
    logic  prot;
    logic  over;
    logic  n_cap;
    logic  pend_v;
  } sts_t;

endpackage

/* src/bev_if.sv */
// ---------------------------------------------------------------------------
// bev_in_if / bev_out_if: stream channels
// Valid/ready channels for request items and result items.
// ---------------------------------------------------------------------------
interface bev_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] tile_x;
  logic signed [31:0] tile_z;
  logic [31:0]        frame;
  logic [23:0]        size_bytes;

  modport source (output valid, mode, tile_x, tile_z, frame, size_bytes, input ready);
  modport sink   (input valid, mode, tile_x, tile_z, frame, size_bytes, output ready);
endinterface

interface bev_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] out_x;
  logic signed [31:0] out_z;
  logic [29:0]        usage_after;
  logic               last;

  modport source (output valid, status, out_x, out_z, usage_after, last, input ready);
  modport sink   (input valid, status, out_x, out_z, usage_after, last, output ready);
endinterface

/* src/bev_ram.sv */
// ---------------------------------------------------------------------------
// bev_ram: generic single-port-write RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module bev_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/bev_dp.sv */
// ---------------------------------------------------------------------------
// bev_dp: residency table datapath
// Entry memories, valid/resident/visited bits, slot scanner, usage total,
// configuration registers, pending eviction and result register.
// ---------------------------------------------------------------------------
module bev_dp #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bev_pkg::cmd_t                       cmd,
  output bev_pkg::sts_t                       sts,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_index,
  input  logic [bev_pkg::BUDGET_W-1:0]        cfg_wdata,
  input  logic [1:0]                          in_mode,
  input  logic [bev_pkg::X_W-1:0]             in_x,
  input  logic [bev_pkg::X_W-1:0]             in_z,
  input  logic [bev_pkg::FRAME_W-1:0]         in_frame,
  input  logic [bev_pkg::SIZE_W-1:0]          in_size,
  output logic [1:0]                          res_status,
  output logic [bev_pkg::X_W-1:0]             res_x,
  output logic [bev_pkg::X_W-1:0]             res_z,
  output logic [bev_pkg::UOUT_W-1:0]          res_usage,
  output logic                                res_last
);
  import bev_pkg::*;

  localparam int unsigned IW   = $clog2(SLOTS);
  localparam int unsigned UW_A = SIZE_W + IW + 1;
  localparam int unsigned UW   = (UW_A > 32) ? UW_A : 32;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  // Configuration registers.
  logic [BUDGET_W-1:0] budget_r;
  logic [PROT_W-1:0]   prot_r;

  // Latched request.
  mode_t               mode_r;
  logic [X_W-1:0]      x_r, z_r;
  logic [FRAME_W-1:0]  frame_r;
  logic [SIZE_W-1:0]   size_r;

  // Per-entry flags.
  logic [SLOTS-1:0]    valid_r, valid_nxt;
  logic [SLOTS-1:0]    res_r, res_nxt;
  logic [SLOTS-1:0]    vis_r, vis_nxt;

  // Scanner.
  logic [IW-1:0]       ptr_r, ptr_nxt;
  logic                busy_r, busy_nxt;
  logic                rdv_r, rdv_nxt;
  logic [IW-1:0]       rdidx_r, rdidx_nxt;
  logic                age_r, age_nxt;

  // Scan results.
  logic                found_r, found_nxt;
  logic [IW-1:0]       match_idx_r, match_idx_nxt;
  logic [SIZE_W-1:0]   match_b_r, match_b_nxt;
  logic                free_f_r, free_f_nxt;
  logic [IW-1:0]       free_idx_r, free_idx_nxt;
  logic                best_f_r, best_f_nxt;
  logic [IW-1:0]       best_idx_r, best_idx_nxt;
  logic [FRAME_W-1:0]  best_lu_r, best_lu_nxt;
  logic [X_W-1:0]      best_x_r, best_x_nxt;
  logic [X_W-1:0]      best_z_r, best_z_nxt;
  logic [SIZE_W-1:0]   best_b_r, best_b_nxt;

  // Usage, eviction count and pending eviction.
  logic [UW-1:0]       usage_r, usage_nxt;
  logic [N_W-1:0]      n_r, n_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [X_W-1:0]      pend_x_r, pend_x_nxt;
  logic [X_W-1:0]      pend_z_r, pend_z_nxt;
  logic [UOUT_W-1:0]   pend_u_r, pend_u_nxt;

  // Memory ports.
  logic [X_W-1:0]      kx_rd, kz_rd;
  logic [FRAME_W-1:0]  lu_rd;
  logic [SIZE_W-1:0]   b_rd;
  logic                we_k, we_lu, we_b;
  logic [IW-1:0]       slot;
  logic [SIZE_W-1:0]   b_wdata;
  logic                hit;
  logic                prot;
  logic [UOUT_W-1:0]   usage_sat;

  bev_ram #(.WIDTH(X_W), .DEPTH(SLOTS)) u_kx (
    .clk, .we(we_k), .waddr(slot), .wdata(x_r), .raddr(ptr_r), .rdata(kx_rd)
  );
  bev_ram #(.WIDTH(X_W), .DEPTH(SLOTS)) u_kz (
    .clk, .we(we_k), .waddr(slot), .wdata(z_r), .raddr(ptr_r), .rdata(kz_rd)
  );
  bev_ram #(.WIDTH(FRAME_W), .DEPTH(SLOTS)) u_lu (
    .clk, .we(we_lu), .waddr(slot), .wdata(frame_r), .raddr(ptr_r), .rdata(lu_rd)
  );
  bev_ram #(.WIDTH(SIZE_W), .DEPTH(SLOTS)) u_b (
    .clk, .we(we_b), .waddr(slot), .wdata(b_wdata), .raddr(ptr_r), .rdata(b_rd)
  );

  // Table update on a touch or fill.
  assign hit     = found_r | free_f_r;
  assign slot    = found_r ? match_idx_r : free_idx_r;
  assign we_k    = cmd.apply_key & hit & ~found_r;
  assign we_lu   = cmd.apply_key & hit & (~found_r | (mode_r == MODE_TOUCH));
  assign we_b    = cmd.apply_key & hit & (~found_r | (mode_r == MODE_FILL));
  assign b_wdata = (mode_r == MODE_FILL) ? size_r : '0;

  // Protection window, formed one bit wider so it cannot wrap.
  assign prot = ({1'b0, best_lu_r} + {{(FRAME_W + 1 - PROT_W){1'b0}}, prot_r})
                >= {1'b0, frame_r};

  // Next-state logic for the scanner, flags and usage.
  always_comb begin
    ptr_nxt       = ptr_r;
    busy_nxt      = busy_r;
    rdv_nxt       = 1'b0;
    rdidx_nxt     = rdidx_r;
    age_nxt       = age_r;
    found_nxt     = found_r;
    match_idx_nxt = match_idx_r;
    match_b_nxt   = match_b_r;
    free_f_nxt    = free_f_r;
    free_idx_nxt  = free_idx_r;
    best_f_nxt    = best_f_r;
    best_idx_nxt  = best_idx_r;
    best_lu_nxt   = best_lu_r;
    best_x_nxt    = best_x_r;
    best_z_nxt    = best_z_r;
    best_b_nxt    = best_b_r;
    valid_nxt     = valid_r;
    res_nxt       = res_r;
    vis_nxt       = vis_r;
    usage_nxt     = usage_r;
    n_nxt         = n_r;
    pend_v_nxt    = pend_v_r;
    pend_x_nxt    = pend_x_r;
    pend_z_nxt    = pend_z_r;
    pend_u_nxt    = pend_u_r;

    // Address issue: one slot per cycle.
    if (cmd.scan_start) begin
      ptr_nxt    = '0;
      busy_nxt   = 1'b1;
      age_nxt    = cmd.scan_age;
      found_nxt  = 1'b0;
      free_f_nxt = 1'b0;
      best_f_nxt = 1'b0;
    end else if (busy_r) begin
      rdv_nxt   = 1'b1;
      rdidx_nxt = ptr_r;
      if (ptr_r == LAST_IDX) begin
        busy_nxt = 1'b0;
      end else begin
        ptr_nxt = ptr_r + 1'b1;
      end
    end

    // Compare stage on the registered read data.
    if (rdv_r) begin
      if (age_r) begin
        if (valid_r[rdidx_r] && res_r[rdidx_r] && !vis_r[rdidx_r] &&
            (!best_f_r || (lu_rd < best_lu_r))) begin
          best_f_nxt   = 1'b1;
          best_idx_nxt = rdidx_r;
          best_lu_nxt  = lu_rd;
          best_x_nxt   = kx_rd;
          best_z_nxt   = kz_rd;
          best_b_nxt   = b_rd;
        end
      end else begin
        if (valid_r[rdidx_r]) begin
          if (!found_r && (kx_rd == x_r) && (kz_rd == z_r)) begin
            found_nxt     = 1'b1;
            match_idx_nxt = rdidx_r;
            match_b_nxt   = b_rd;
          end
        end else if (!free_f_r) begin
          free_f_nxt   = 1'b1;
          free_idx_nxt = rdidx_r;
        end
      end
    end

    // Touch or fill applied to the found or created slot.
    if (cmd.apply_key && hit) begin
      valid_nxt[slot] = 1'b1;
      if (mode_r == MODE_FILL) begin
        res_nxt[slot] = 1'b1;
        if (found_r && res_r[slot]) begin
          usage_nxt = usage_r - UW'(match_b_r) + UW'(size_r);
        end else begin
          usage_nxt = usage_r + UW'(size_r);
        end
      end
    end

    // Start of an enforce pass.
    if (cmd.init_enf) begin
      vis_nxt    = '0;
      n_nxt      = '0;
      pend_v_nxt = 1'b0;
    end

    // Visit the oldest candidate; evict it unless protected.
    if (cmd.decide && best_f_r) begin
      vis_nxt[best_idx_r] = 1'b1;
      if (!prot) begin
        res_nxt[best_idx_r] = 1'b0;
        usage_nxt  = usage_r - UW'(best_b_r);
        n_nxt      = n_r + 1'b1;
        pend_v_nxt = 1'b1;
        pend_x_nxt = best_x_r;
        pend_z_nxt = best_z_r;
      end
    end

    usage_sat = (usage_nxt > UW'(USAGE_MAX)) ? USAGE_MAX : usage_nxt[UOUT_W-1:0];
    if (cmd.decide && best_f_r && !prot) begin
      pend_u_nxt = usage_sat;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      res_r    <= '0;
      usage_r  <= '0;
      busy_r   <= 1'b0;
      rdv_r    <= 1'b0;
      pend_v_r <= 1'b0;
      n_r      <= '0;
      budget_r <= BUDGET_RESET;
      prot_r   <= PROTECT_RESET;
    end else begin
      valid_r  <= valid_nxt;
      res_r    <= res_nxt;
      usage_r  <= usage_nxt;
      busy_r   <= busy_nxt;
      rdv_r    <= rdv_nxt;
      pend_v_r <= pend_v_nxt;
      n_r      <= n_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_BUDGET:  budget_r <= (cfg_wdata < BUDGET_FLOOR) ? BUDGET_FLOOR : cfg_wdata;
          REG_PROTECT: prot_r   <= cfg_wdata[PROT_W-1:0];
          default:     ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    rdidx_r     <= rdidx_nxt;
    age_r       <= age_nxt;
    found_r     <= found_nxt;
    match_idx_r <= match_idx_nxt;
    match_b_r   <= match_b_nxt;
    free_f_r    <= free_f_nxt;
    free_idx_r  <= free_idx_nxt;
    best_f_r    <= best_f_nxt;
    best_idx_r  <= best_idx_nxt;
    best_lu_r   <= best_lu_nxt;
    best_x_r    <= best_x_nxt;
    best_z_r    <= best_z_nxt;
    best_b_r    <= best_b_nxt;
    vis_r       <= vis_nxt;
    pend_x_r    <= pend_x_nxt;
    pend_z_r    <= pend_z_nxt;
    pend_u_r    <= pend_u_nxt;
    if (cmd.latch) begin
      mode_r  <= mode_t'(in_mode);
      x_r     <= in_x;
      z_r     <= in_z;
      frame_r <= in_frame;
      size_r  <= in_size;
    end
    // Result register: a direct result or the held eviction.
    if (cmd.emit_direct) begin
      res_status <= cmd.emit_status;
      res_x      <= '0;
      res_z      <= '0;
      res_usage  <= usage_sat;
      res_last   <= 1'b1;
    end else if (cmd.emit_pend) begin
      res_status <= ST_EVICTED;
      res_x      <= pend_x_r;
      res_z      <= pend_z_r;
      res_usage  <= pend_u_r;
      res_last   <= cmd.emit_last;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.mode      = mode_r;
    sts.scan_done = ~busy_r & ~rdv_r;
    sts.hit       = hit;
    sts.best_ok   = best_f_r;
    sts.prot      = prot;
    sts.over      = usage_r > UW'(budget_r);
    sts.n_cap     = (n_r == RESULT_CAP);
    sts.pend_v    = pend_v_r;
  end

endmodule

/* src/bev_ctrl.sv */
// ---------------------------------------------------------------------------
// bev_ctrl: request sequencer
// Steps a request through key scan and update, or through repeated
// oldest-first scans for enforce, and hands results to the output.
// ---------------------------------------------------------------------------
module bev_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  output logic          in_rdy,
  output logic          out_vld,
  input  logic          out_rdy,
  output bev_pkg::cmd_t cmd,
  input  bev_pkg::sts_t sts
);
  import bev_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_SCANK  = 8'b0000_0100,
    S_APPLY  = 8'b0000_1000,
    S_SCANA  = 8'b0001_0000,
    S_DECIDE = 8'b0010_0000,
    S_LOOP   = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   ret_loop_r, ret_loop_nxt;

  assign in_rdy  = (state_r == S_IDLE);
  assign out_vld = (state_r == S_OUT);

  // Sequencing.
  always_comb begin
    state_nxt       = state_r;
    ret_loop_nxt    = ret_loop_r;
    cmd             = '0;
    cmd.emit_status = ST_DONE;
    case (state_r)
      S_IDLE: begin
        cmd.latch = in_fire;
        if (in_fire) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        ret_loop_nxt = 1'b0;
        case (sts.mode)
          MODE_TOUCH, MODE_FILL: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCANK;
          end
          MODE_ENFORCE: begin
            if (sts.over) begin
              cmd.init_enf   = 1'b1;
              cmd.scan_start = 1'b1;
              cmd.scan_age   = 1'b1;
              state_nxt      = S_SCANA;
            end else begin
              cmd.emit_direct = 1'b1;
              state_nxt       = S_OUT;
            end
          end
          default: begin
            cmd.emit_direct = 1'b1;
            state_nxt       = S_OUT;
          end
        endcase
      end
      S_SCANK: begin
        if (sts.scan_done) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply_key   = 1'b1;
        cmd.emit_direct = 1'b1;
        cmd.emit_status = sts.hit ? ST_DONE : ST_FULL;
        state_nxt       = S_OUT;
      end
      S_SCANA: begin
        if (sts.scan_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (!sts.best_ok) begin
          // Every candidate visited: close the pass.
          ret_loop_nxt = 1'b0;
          state_nxt    = S_OUT;
          if (sts.pend_v) begin
            cmd.emit_pend = 1'b1;
            cmd.emit_last = 1'b1;
          end else begin
            cmd.emit_direct = 1'b1;
            cmd.emit_status = ST_NONE;
          end
        end else if (!sts.prot && sts.pend_v) begin
          // A newer eviction follows, so the held one is not the last.
          cmd.emit_pend = 1'b1;
          ret_loop_nxt  = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        if (sts.over && !sts.n_cap) begin
          cmd.scan_start = 1'b1;
          cmd.scan_age   = 1'b1;
          state_nxt      = S_SCANA;
        end else begin
          cmd.emit_pend = 1'b1;
          cmd.emit_last = 1'b1;
          ret_loop_nxt  = 1'b0;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_rdy) state_nxt = ret_loop_r ? S_LOOP : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_loop_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ret_loop_r <= ret_loop_nxt;
    end
  end

endmodule

/* src/budget_eviction_oldest_first.sv */
// ---------------------------------------------------------------------------
// budget_eviction_oldest_first: tile residency table with byte budget
// Touch, fill and oldest-first eviction over a keyed table of SLOTS entries.
// ---------------------------------------------------------------------------
//  Channel   Direction  Transfer carries
//  in_ch     sink       mode, tile_x, tile_z, frame, size_bytes
//  out_ch    source     status, out_x, out_z, usage_after, last
//  cfg_*     write      byte_budget (index 0), protect_frames (index 1)
//
//  Touch and fill make one key memory read per slot. Enforce runs one
//  oldest-first scan per visited entry; each result waits on out_ch.ready.
//  One request is in flight; in_ch.ready is high only between requests.
//  Reset clears the valid and resident bits and the usage total at once.
// ---------------------------------------------------------------------------
module budget_eviction_oldest_first #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bev_in_if.sink                       in_ch,
  bev_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [bev_pkg::BUDGET_W-1:0] cfg_wdata
);
  import bev_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [X_W-1:0]    res_x, res_z;

  bev_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire (in_ch.valid & in_ch.ready),
    .in_rdy  (in_ch.ready),
    .out_vld (out_ch.valid),
    .out_rdy (out_ch.ready),
    .cmd, .sts
  );

  bev_dp #(.SLOTS(SLOTS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .cfg_we, .cfg_index, .cfg_wdata,
    .in_mode    (in_ch.mode),
    .in_x       (in_ch.tile_x),
    .in_z       (in_ch.tile_z),
    .in_frame   (in_ch.frame),
    .in_size    (in_ch.size_bytes),
    .res_status (out_ch.status),
    .res_x,
    .res_z,
    .res_usage  (out_ch.usage_after),
    .res_last   (out_ch.last)
  );

  assign out_ch.out_x = res_x;
  assign out_ch.out_z = res_z;

endmodule
